>>> rtl/core/umidi_pkg.sv
// Shared constants and types for the USB MIDI packet parser.
`timescale 1ns / 1ps

package umidi_pkg;

  localparam int SYSEX_DEPTH = 64;
  localparam int SYSEX_AW    = $clog2(SYSEX_DEPTH);
  localparam int SYSEX_CW    = $clog2(SYSEX_DEPTH + 1);

  typedef logic [7:0]            byte_t;
  typedef logic [2:0]            kind_t;
  typedef logic [3:0]            cin_t;
  typedef logic [SYSEX_CW-1:0]   sx_count_t;
  typedef logic [SYSEX_AW-1:0]   sx_addr_t;

  localparam byte_t SX_START = 8'hF0;
  localparam byte_t SX_END   = 8'hF7;

  // code index numbers
  localparam cin_t CIN_SX_CONT = 4'h4;
  localparam cin_t CIN_SX_END1 = 4'h5;
  localparam cin_t CIN_SX_END2 = 4'h6;
  localparam cin_t CIN_SX_END3 = 4'h7;
  localparam cin_t CIN_NOTE_OFF = 4'h8;
  localparam cin_t CIN_NOTE_ON  = 4'h9;
  localparam cin_t CIN_CTRL     = 4'hB;

  // result kinds
  localparam kind_t KIND_NOTE_OFF = 3'd0;
  localparam kind_t KIND_NOTE_ON  = 3'd1;
  localparam kind_t KIND_CTRL     = 3'd2;
  localparam kind_t KIND_SYSEX    = 3'd3;
  localparam kind_t KIND_EMPTY    = 3'd4;

  // event_enable bit positions
  localparam int EN_NOTE_OFF = 0;
  localparam int EN_NOTE_ON  = 1;
  localparam int EN_CTRL     = 2;
  localparam int EN_SYSEX    = 3;

  localparam int         APB_AW            = 3;
  localparam logic [0:0] REG_EVENT_ENABLE  = 1'b0;
  localparam logic [3:0] EVENT_ENABLE_RST  = 4'hF;

endpackage

>>> rtl/core/umidi_if.sv
// Valid/ready channel interfaces for packets in and events out.
`timescale 1ns / 1ps

interface umidi_in_if;
  logic           valid;
  logic           ready;
  umidi_pkg::byte_t header;
  umidi_pkg::byte_t first_byte;
  umidi_pkg::byte_t second_byte;
  umidi_pkg::byte_t third_byte;

  modport source (output valid, header, first_byte, second_byte, third_byte, input ready);
  modport sink   (input valid, header, first_byte, second_byte, third_byte, output ready);
endinterface

interface umidi_out_if;
  logic             valid;
  logic             ready;
  umidi_pkg::kind_t kind;
  logic [3:0]       channel;
  umidi_pkg::byte_t key_or_controller;
  umidi_pkg::byte_t velocity_or_value;
  umidi_pkg::byte_t sysex_data;
  logic [6:0]       sysex_length;
  logic             last;

  modport source (output valid, kind, channel, key_or_controller, velocity_or_value,
                  sysex_data, sysex_length, last, input ready);
  modport sink   (input valid, kind, channel, key_or_controller, velocity_or_value,
                  sysex_data, sysex_length, last, output ready);
endinterface

>>> rtl/core/usb_midi_packet_parser.sv
// USB MIDI event packet parser top level with its sysex byte store.
`timescale 1ns / 1ps
//
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    one 4-byte event packet
//  out_ch   out  valid/ready    one event or one buffered sysex byte
//  apb      in   psel/penable   event_enable register at byte address 0
//
//  Note and control packets: accepted in ST_IDLE, event loaded in ST_EMIT once the output is free.
//  Sysex packets: bytes are appended one at a time in ST_APPEND (one store write port).
//  End packets drain the store byte by byte, each through a read (ST_RD) and a load (ST_LOAD).
//  Reset clears the byte count and sets event_enable to 15; store is not cleared.
//  A stalled output holds its word; packets keep being taken until one needs the output.

module usb_midi_packet_parser (
  input  logic                          clk,
  input  logic                          rst,
  umidi_in_if.sink                      in_ch,
  umidi_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [umidi_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_RD     = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;

  localparam int CW = umidi_pkg::SYSEX_CW;
  localparam int AW = umidi_pkg::SYSEX_AW;
  localparam umidi_pkg::sx_count_t DEPTH_C = CW'(umidi_pkg::SYSEX_DEPTH);

  logic [2:0]               st;
  logic [3:0]               event_enable;
  umidi_pkg::sx_count_t     count;
  umidi_pkg::byte_t         pend [4];
  logic [1:0]               idx;
  logic [1:0]               n_pend;
  logic                     deliver;
  umidi_pkg::sx_addr_t      rd_ptr;
  umidi_pkg::kind_t         ev_kind;
  logic [3:0]               ev_ch;
  umidi_pkg::byte_t         ev_key;
  umidi_pkg::byte_t         ev_vel;
  logic                     out_valid;

  umidi_pkg::byte_t         mem [umidi_pkg::SYSEX_DEPTH];
  umidi_pkg::byte_t         rdata;
  logic                     mem_we;
  logic                     mem_re;

  logic                     in_acc;
  logic                     load_ok;
  logic                     out_load;
  logic                     rd_last;
  logic                     cfg_we;
  umidi_pkg::cin_t          cin;
  umidi_pkg::byte_t         b1, b2, b3;

  assign in_ch.ready = (st == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cin         = in_ch.header[3:0];
  assign b1          = in_ch.first_byte;
  assign b2          = in_ch.second_byte;
  assign b3          = in_ch.third_byte;

  assign load_ok  = !out_valid || out_ch.ready;
  assign out_load = ((st == ST_EMIT) || (st == ST_LOAD)) && load_ok;
  assign rd_last  = (CW'(rd_ptr) + CW'(1)) == count;

  // store is only touched by one phase at a time, so no forwarding is needed
  assign mem_we = (st == ST_APPEND) && (idx != n_pend) && (count < DEPTH_C);
  assign mem_re = (st == ST_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= pend[idx];
    end
    if (mem_re) begin
      rdata <= mem[rd_ptr];
    end
  end

  // APB
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[umidi_pkg::APB_AW-1:2] == umidi_pkg::REG_EVENT_ENABLE);
  assign prdata = (paddr[umidi_pkg::APB_AW-1:2] == umidi_pkg::REG_EVENT_ENABLE) ?
                  {28'd0, event_enable} : 32'd0;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      count        <= '0;
      event_enable <= umidi_pkg::EVENT_ENABLE_RST;
      out_valid    <= 1'b0;
      idx          <= '0;
      n_pend       <= '0;
      deliver      <= 1'b0;
      rd_ptr       <= '0;
    end else begin
      if (cfg_we) begin
        event_enable <= pwdata[3:0];
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        ST_IDLE: begin
          idx <= '0;
          if (in_acc) begin
            unique case (cin)
              umidi_pkg::CIN_SX_CONT: begin
                deliver <= 1'b0;
                st      <= ST_APPEND;
                if (b1 == umidi_pkg::SX_START) begin
                  count  <= '0;
                  n_pend <= 2'd2;
                end else begin
                  n_pend <= 2'd3;
                end
              end
              umidi_pkg::CIN_SX_END1: begin
                if (b1 == umidi_pkg::SX_END) begin
                  deliver <= 1'b1;
                  n_pend  <= 2'd0;
                  st      <= ST_APPEND;
                end
              end
              umidi_pkg::CIN_SX_END2: begin
                if (b2 == umidi_pkg::SX_END) begin
                  deliver <= 1'b1;
                  n_pend  <= 2'd1;
                  st      <= ST_APPEND;
                end
              end
              umidi_pkg::CIN_SX_END3: begin
                if (b3 == umidi_pkg::SX_END) begin
                  deliver <= 1'b1;
                  n_pend  <= 2'd2;
                  st      <= ST_APPEND;
                end
              end
              umidi_pkg::CIN_NOTE_OFF: begin
                if (event_enable[umidi_pkg::EN_NOTE_OFF]) begin
                  st <= ST_EMIT;
                end
              end
              umidi_pkg::CIN_NOTE_ON: begin
                if ((b3 == 8'd0) ? event_enable[umidi_pkg::EN_NOTE_OFF]
                                 : event_enable[umidi_pkg::EN_NOTE_ON]) begin
                  st <= ST_EMIT;
                end
              end
              umidi_pkg::CIN_CTRL: begin
                if (event_enable[umidi_pkg::EN_CTRL]) begin
                  st <= ST_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_APPEND: begin
          if (idx != n_pend) begin
            if (count < DEPTH_C) begin
              count <= count + CW'(1);
            end
            idx <= idx + 2'd1;
          end else if (deliver && event_enable[umidi_pkg::EN_SYSEX]) begin
            rd_ptr <= '0;
            st     <= (count == '0) ? ST_EMIT : ST_RD;
          end else begin
            st <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (load_ok) begin
            st <= ST_IDLE;
          end
        end
        ST_RD: begin
          st <= ST_LOAD;
        end
        ST_LOAD: begin
          if (load_ok) begin
            if (rd_last) begin
              st <= ST_IDLE;
            end else begin
              rd_ptr <= rd_ptr + AW'(1);
              st     <= ST_RD;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_ch  <= b1[3:0];
      ev_key <= b2;
      ev_vel <= b3;
      if (cin == umidi_pkg::CIN_CTRL) begin
        ev_kind <= umidi_pkg::KIND_CTRL;
      end else if ((cin == umidi_pkg::CIN_NOTE_ON) && (b3 != 8'd0)) begin
        ev_kind <= umidi_pkg::KIND_NOTE_ON;
      end else begin
        ev_kind <= umidi_pkg::KIND_NOTE_OFF;
      end
      if ((cin == umidi_pkg::CIN_SX_CONT) && (b1 == umidi_pkg::SX_START)) begin
        pend[0] <= b2;
        pend[1] <= b3;
      end else begin
        pend[0] <= b1;
        pend[1] <= b2;
      end
      pend[2] <= b3;
      pend[3] <= b3;
    end else if ((st == ST_APPEND) && (idx == n_pend)) begin
      // empty sysex delivery reuses the event path
      ev_kind <= umidi_pkg::KIND_EMPTY;
      ev_ch   <= '0;
      ev_key  <= '0;
      ev_vel  <= '0;
    end

    if (out_load) begin
      if (st == ST_EMIT) begin
        out_ch.kind              <= ev_kind;
        out_ch.channel           <= ev_ch;
        out_ch.key_or_controller <= ev_key;
        out_ch.velocity_or_value <= ev_vel;
        out_ch.sysex_data        <= '0;
        out_ch.sysex_length      <= '0;
        out_ch.last              <= 1'b1;
      end else begin
        out_ch.kind              <= umidi_pkg::KIND_SYSEX;
        out_ch.channel           <= '0;
        out_ch.key_or_controller <= '0;
        out_ch.velocity_or_value <= '0;
        out_ch.sysex_data        <= rdata;
        out_ch.sysex_length      <= 7'(count);
        out_ch.last              <= rd_last;
      end
    end
  end

  assign out_ch.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("sysex count above store depth");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (CW'(rd_ptr) < count))
    else $error("store read beyond written bytes");

  a_drain_count_stable: assert property (@(posedge clk) disable iff (rst)
    ((st == ST_RD) || (st == ST_LOAD)) |=> $stable(count))
    else $error("count changed during drain");

  a_sysex_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_ch.kind == umidi_pkg::KIND_SYSEX)) |->
      (out_ch.sysex_length != 7'd0))
    else $error("sysex byte word with zero length");

endmodule
